/* rtl/dpst_pkg.sv */
package dpst_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int ADDR_W      = 64;
   localparam int MIN_SHIFT   = 12;
   localparam int MAX_SHIFT   = 20;
   localparam int ENTRY_W     = ADDR_W - MIN_SHIFT;
   localparam int THR_W       = 8;
   localparam int SHIFT_W     = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(100);
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(14);

   typedef enum logic [0:0] {
      REG_FLUSH_THRESHOLD = 1'b0,
      REG_PAGE_SHIFT      = 1'b1
   } csr_index_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch a new write address
      logic scan;      // search the page set
      logic update;    // commit insert or drop
      logic insert;    // page was not found in the set
      logic fl_read;   // read one stored page for the flush
      logic load;      // move the read page into the output register
      logic clear;     // end of flush: empty set and counters
   } dpst_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic scan_done;
      logic flush_due;
      logic out_free;
      logic last;
   } dpst_status_type;

endpackage

/* rtl/dpst_csr.sv */
module dpst_csr
   import dpst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [THR_W-1:0]      threshold,
   output logic [SHIFT_W-1:0]    eff_shift
);

   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic               wr_en;
   csr_index_type      idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_index_type'(csr_paddr[2]);

   always_comb begin
      thr_in   = thr_ff;
      shift_in = shift_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FLUSH_THRESHOLD: thr_in   = csr_pwdata[THR_W-1:0];
            REG_PAGE_SHIFT:      shift_in = csr_pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FLUSH_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_PAGE_SHIFT:      csr_prdata = CSR_DATA_W'(shift_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // clamp the page shift to the supported range
   always_comb begin
      if (shift_ff < SHIFT_W'(MIN_SHIFT)) begin
         eff_shift = SHIFT_W'(MIN_SHIFT);
      end else if (shift_ff > SHIFT_W'(MAX_SHIFT)) begin
         eff_shift = SHIFT_W'(MAX_SHIFT);
      end else begin
         eff_shift = shift_ff;
      end
   end

   assign threshold = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         shift_ff <= SHIFT_RESET;
      end else begin
         thr_ff   <= thr_in;
         shift_ff <= shift_in;
      end
   end

endmodule

/* rtl/dpst_ctrl.sv */
module dpst_ctrl
   import dpst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  dpst_status_type status,
   output dpst_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_FL_READ,
      ST_FL_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (status.hit || status.scan_done) begin
               found_in = status.hit;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.insert = !found_ff;
            state_in   = status.flush_due ? ST_FL_READ : ST_IDLE;
         end
         ST_FL_READ: begin
            cmd.fl_read = 1'b1;
            state_in    = ST_FL_LOAD;
         end
         ST_FL_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               if (status.last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_FL_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

endmodule

/* rtl/dpst_dpath.sv */
module dpst_dpath
   import dpst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ADDR_W-1:0]  req_tdata,
   input  logic [THR_W-1:0]   threshold,
   input  logic [SHIFT_W-1:0] eff_shift,
   input  dpst_cmd_type       cmd,
   output dpst_status_type    status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [ADDR_W-1:0]  rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);

   logic [ENTRY_W-1:0] mem [STORE_DEPTH];

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_en;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [THR_W-1:0]   wc_ff, wc_in;
   logic               drop_ff, drop_in;
   logic               full;
   logic               wr_en;
   logic [SHIFT_W-1:0] sh_off;
   logic [ENTRY_W-1:0] mask;
   logic               ovalid_ff, ovalid_in;
   logic [ADDR_W-1:0]  odata_ff;
   logic               olast_ff;
   logic               ouser_ff;

   assign sh_off   = eff_shift - SHIFT_W'(MIN_SHIFT);
   assign mask     = {ENTRY_W{1'b1}} << sh_off;
   assign entry_in = req_tdata[ADDR_W-1:MIN_SHIFT] & mask;
   assign full     = (count_ff >= CNT_W'(STORE_DEPTH));
   assign wr_en    = cmd.update && cmd.insert && !full;

   assign status.hit       = rd_vld_ff && (rd_data_ff == entry_ff);
   assign status.scan_done = (ptr_ff == count_ff) && !rd_vld_ff;
   assign status.flush_due = (wc_ff >= threshold);
   assign status.out_free  = !ovalid_ff || rsp_tready;
   assign status.last      = (({1'b0, ptr_ff} + (CNT_W + 1)'(1)) == {1'b0, count_ff});

   assign rd_en = (cmd.scan && (ptr_ff < count_ff) && !status.hit) || cmd.fl_read;

   always_comb begin
      ptr_in    = ptr_ff;
      rd_vld_in = 1'b0;
      count_in  = count_ff;
      wc_in     = wc_ff;
      drop_in   = drop_ff;
      if (cmd.capture) begin
         ptr_in = '0;
         wc_in  = wc_ff + THR_W'(1);
      end
      if (cmd.scan && rd_en) begin
         ptr_in    = ptr_ff + CNT_W'(1);
         rd_vld_in = 1'b1;
      end
      if (cmd.update) begin
         ptr_in = '0;
         if (cmd.insert && full) begin
            drop_in = 1'b1;
         end else if (cmd.insert) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.load) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         wc_in    = '0;
         drop_in  = 1'b0;
      end
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.load) begin
         ovalid_in = 1'b1;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= entry_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_ff <= entry_in;
      end
      if (cmd.load) begin
         odata_ff <= {rd_data_ff, {MIN_SHIFT{1'b0}}};
         olast_ff <= status.last;
         ouser_ff <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         count_ff  <= '0;
         wc_ff     <= '0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_vld_in;
         count_ff  <= count_in;
         wc_ff     <= wc_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("page count beyond store depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!ovalid_ff || rsp_tready))
      else $error("output register overwritten");

   a_hit_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && !cmd.insert) |=> (count_ff == $past(count_ff)))
      else $error("known page changed the set");

   a_clear_last: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (rsp_tvalid && rsp_tlast && count_ff == '0))
      else $error("flush ended without last page");
`endif

endmodule

/* rtl/dirty_page_set_tracker.sv */
// channel   dir  handshake                    payload
// req_      in   req_tvalid / req_tready      tdata = write_address[63:0]
// rsp_      out  rsp_tvalid / rsp_tready      tdata = page_address, tlast = last_page,
//                                             tuser = overflow
// csr_      in   psel / penable / pready      flush_threshold @0x0, page_shift @0x4
//
// Search: the set search reads one stored page per cycle from the page memory, so a write
//   takes longer as the set grows.
// A flush reads each page from memory, then loads it into the output register.
// Reset: synchronous, active high; empties the set and counters, loads register defaults.
// Stalls: rsp_tready low holds only the flush; a new write is taken while the last
//   flushed page still waits in the output register.
module dirty_page_set_tracker
   import dpst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ADDR_W-1:0]     req_tdata,   // [63:0] write_address
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ADDR_W-1:0]     rsp_tdata,   // [63:0] page_address
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // [0] overflow
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [THR_W-1:0]   threshold;
   logic [SHIFT_W-1:0] eff_shift;
   dpst_cmd_type       cmd;
   dpst_status_type    status;

   // registers: threshold and clamped page shift
   dpst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold),
      .eff_shift   (eff_shift)
   );

   // sequence: accept, search, commit, then flush run when the count is due
   dpst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // page memory, counters, overflow flag and output register
   dpst_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .threshold  (threshold),
      .eff_shift  (eff_shift),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
